[src/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

	localparam int ACT_W   = 3;
	localparam int ADDR_W  = 32;
	localparam int BYTES_W = 32;
	localparam int LEN_W   = 13;
	localparam int CNT_W   = 13;
	localparam int KIB_W   = 15;

	localparam logic [ACT_W-1:0] ACT_INIT      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ALLOC_ONE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_ALLOC_RUN = 3'd2;
	localparam logic [ACT_W-1:0] ACT_FREE_RUN  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RELEASE   = 3'd4;
	localparam logic [ACT_W-1:0] ACT_RESERVE   = 3'd5;

	localparam logic [KIB_W-1:0] KIB_RESET = 15'd16384;

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [ADDR_W-1:0]  base_address;
		logic [BYTES_W-1:0] region_bytes;
		logic [LEN_W-1:0]   run_length;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] block_address;
		logic [CNT_W-1:0]  used_count;
		logic [CNT_W-1:0]  free_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MRD,
		ST_MWR,
		ST_ZRD,
		ST_ZWR,
		ST_DONE
	} state_t;

endpackage

[src/bitmap_block_allocator.sv]
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   bba_pkg::req_t (action, base, bytes, run length)
// rsp      out        rsp_valid/rsp_stall   bba_pkg::rsp_t (ok, address, used, free)
// cfg      in         cfg_wr_en             cfg_wr_data (memory size in KiB)
//
// One transaction at a time. Initialize and rejected requests go straight to the response.
// Marking a range reads and rewrites every word that it touches; a release adds the block-zero fixup.
// Allocation scans the bitmap memory one word per cycle through its single read port,
// over up to (block count / WORD_BITS) words, then marks the run as above.
// Reset is immediate: per-word valid flags make every word read as all used.
// A stalled result sits in the output register; the next request is taken meanwhile.

module bitmap_block_allocator #(
	parameter int NUM_BLOCKS  = 4096,
	parameter int BLOCK_BYTES = 4096,
	parameter int WORD_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bba_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bba_pkg::rsp_t                 rsp,
	input  logic                          cfg_wr_en,
	input  logic [bba_pkg::KIB_W-1:0]     cfg_wr_data
);

	import bba_pkg::*;

	localparam int WB    = WORD_BITS;
	localparam int NW    = (NUM_BLOCKS + WB - 1) / WB;
	localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
	localparam int BW    = $clog2(WB);
	localparam int XW    = AW + BW;
	localparam int BSH   = $clog2(BLOCK_BYTES);
	localparam int CW    = $clog2(NUM_BLOCKS + 1);
	localparam int SW    = ADDR_W - BSH;
	localparam int IW    = 33;
	localparam int CFG_W = KIB_W + 10;
	localparam int RST_RAW = int'(KIB_RESET) * 1024 / BLOCK_BYTES;
	localparam int BC_RESET = (RST_RAW > NUM_BLOCKS) ? NUM_BLOCKS : RST_RAW;
	localparam logic [WB-1:0] ONES = {WB{1'b1}};

	// Bitmap storage: one word per entry, 1 means used.
	logic [WB-1:0] mem [NW];
	logic [NW-1:0] vld_q;
	logic [WB-1:0] rd_s1;
	logic          rd_vld_s1;

	logic          mem_re, mem_we;
	logic [AW-1:0] mem_ra, mem_wa;
	logic [WB-1:0] mem_wd;

	state_t state_q, state_d, dec_next;

	logic [KIB_W-1:0] kib_q;
	logic [CW-1:0]    bc_q, used_q, n_q;
	logic [XW-1:0]    start_q, last_q;
	logic [AW-1:0]    wcur_q;
	logic             set_q, up_q, release_q, ok_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0] len_q, run_q;
	logic [AW:0]      scan_q, rd_idx_q;
	logic             pend_s1;
	logic [AW-1:0]    ev_idx_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic accept;
	assign accept = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Block count from the configured size.
	logic [CFG_W-1:0] cfg_raw;
	logic [CW-1:0]    cfg_count;
	assign cfg_raw = {kib_q, 10'b0} >> BSH;
	assign cfg_count = (cfg_raw > CFG_W'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(cfg_raw);

	// Request decode.
	logic [SW-1:0]    start_raw, bytes_blk;
	logic [IW-1:0]    n_raw, room, n_clip;
	logic             in_rng;
	logic [XW-1:0]    st_dec, last_dec;
	logic [LEN_W-1:0] len_a;
	logic [AW:0]      scan_dec;
	logic [CW-BW-1:0] bc_words;

	assign start_raw = req.base_address[ADDR_W-1:BSH];
	assign bytes_blk = req.region_bytes[BYTES_W-1:BSH];
	assign n_raw = (req.action == ACT_FREE_RUN) ? IW'(req.run_length) : IW'(bytes_blk);
	assign in_rng = IW'(start_raw) < IW'(NUM_BLOCKS);
	assign room = IW'(NUM_BLOCKS) - IW'(start_raw);
	assign n_clip = !in_rng ? '0 : ((n_raw > room) ? room : n_raw);
	assign st_dec = XW'(start_raw);
	assign last_dec = XW'(IW'(start_raw) + n_clip - IW'(1));
	assign len_a = (req.action == ACT_ALLOC_ONE) ? LEN_W'(1) : req.run_length;
	assign bc_words = bc_q[CW-1:BW];
	assign scan_dec = (IW'(bc_words) > IW'(NW)) ? (AW+1)'(NW) : (AW+1)'(bc_words);

	always_comb begin
		case (req.action)
			ACT_INIT: dec_next = ST_DONE;
			ACT_ALLOC_ONE, ACT_ALLOC_RUN: begin
				if (len_a == '0 || used_q >= bc_q || scan_dec == '0)
					dec_next = ST_DONE;
				else
					dec_next = ST_SCAN;
			end
			ACT_FREE_RUN, ACT_RELEASE, ACT_RESERVE: begin
				if (req.action == ACT_FREE_RUN && req.run_length == '0)
					dec_next = ST_DONE;
				else if (n_clip != '0)
					dec_next = ST_MRD;
				else if (req.action == ACT_RELEASE)
					dec_next = ST_ZRD;
				else
					dec_next = ST_DONE;
			end
			default: dec_next = ST_DONE;
		endcase
	end

	// Scan of one word for the first free run of len_q.
	function automatic logic [WB-1:0] run_hits(input logic [WB-1:0] w,
			input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] r);
		logic [WB-1:0]    h;
		logic [WB-1:0]    m;
		logic [BW+1:0]    lc;
		logic [LEN_W:0]   tot;
		lc = (len > LEN_W'(WB)) ? (BW+2)'(WB + 1) : (BW+2)'(len);
		for (int j = 0; j < WB; j++) begin
			for (int k = 0; k < WB; k++)
				m[k] = (k <= j) && (((BW+2)'(k) + lc) >= (BW+2)'(j + 1));
			tot = {1'b0, r} + (LEN_W+1)'(j + 1);
			if (lc <= (BW+2)'(j + 1))
				h[j] = ((w & m) == '0);
			else
				h[j] = ((w & m) == '0) && (tot >= {1'b0, len});
		end
		return h;
	endfunction

	logic [WB-1:0]    ev_word, hits;
	logic             found;
	logic [BW-1:0]    hj, hs;
	logic [LEN_W:0]   run_sum;
	logic [LEN_W-1:0] run_nx;
	logic [XW-1:0]    hit_last, hit_first;

	assign ev_word = rd_vld_s1 ? rd_s1 : ONES;
	assign hits = run_hits(ev_word, len_q, run_q);
	assign run_sum = {1'b0, run_q} + (LEN_W+1)'(WB);

	always_comb begin
		found = 1'b0;
		hj = '0;
		for (int j = WB - 1; j >= 0; j--) begin
			if (hits[j]) begin
				found = 1'b1;
				hj = BW'(j);
			end
		end
	end

	always_comb begin
		hs = '0;
		for (int j = 0; j < WB; j++) begin
			if (ev_word[j])
				hs = BW'(j);
		end
		if (ev_word == '0)
			run_nx = (run_sum > {1'b0, len_q}) ? len_q : LEN_W'(run_sum);
		else
			run_nx = LEN_W'(BW'(WB - 1) - hs);
	end

	assign hit_last = {ev_idx_s1, hj};
	assign hit_first = hit_last - XW'(len_q - LEN_W'(1));

	logic scan_hit, scan_end;
	assign scan_hit = pend_s1 && found;
	assign scan_end = pend_s1 && !found && ((AW+1)'(ev_idx_s1) == scan_q - (AW+1)'(1));

	// Mark step: mask the current word.
	logic [AW-1:0] ws, we;
	logic [BW-1:0] lo, hi;
	logic [WB-1:0] mmask, mdata;
	assign ws = start_q[XW-1:BW];
	assign we = last_q[XW-1:BW];
	assign lo = (wcur_q == ws) ? start_q[BW-1:0] : '0;
	assign hi = (wcur_q == we) ? last_q[BW-1:0] : BW'(WB - 1);
	assign mmask = (ONES << lo) & (ONES >> (BW'(WB - 1) - hi));
	assign mdata = set_q ? (ev_word | mmask) : (ev_word & ~mmask);

	// Used count moves.
	logic [CW:0]   cup_sum;
	logic [CW-1:0] cup, cdown;
	assign cup_sum = {1'b0, used_q} + {1'b0, n_q};
	assign cup = (cup_sum > {1'b0, bc_q}) ? bc_q : CW'(cup_sum);
	assign cdown = (n_q >= used_q) ? '0 : (used_q - n_q);

	logic out_free;
	assign out_free = !rsp_valid_q || !rsp_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = dec_next;
			ST_SCAN: begin
				if (scan_hit)
					state_d = ST_MRD;
				else if (scan_end)
					state_d = ST_DONE;
			end
			ST_MRD: state_d = ST_MWR;
			ST_MWR: begin
				if (wcur_q == we)
					state_d = release_q ? ST_ZRD : ST_DONE;
			end
			ST_ZRD: state_d = ST_ZWR;
			ST_ZWR: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		mem_re = 1'b0;
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = mdata;
		case (state_q)
			ST_SCAN: begin
				mem_re = (rd_idx_q < scan_q) && !scan_hit;
				mem_ra = rd_idx_q[AW-1:0];
			end
			ST_MRD: begin
				mem_re = 1'b1;
				mem_ra = wcur_q;
			end
			ST_MWR: begin
				mem_we = 1'b1;
				mem_wa = wcur_q;
				mem_re = (wcur_q != we);
				mem_ra = wcur_q + AW'(1);
			end
			ST_ZRD: mem_re = 1'b1;
			ST_ZWR: begin
				mem_we = 1'b1;
				mem_wd = ev_word | WB'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_s1 <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_re)
				rd_vld_s1 <= vld_q[mem_ra];
			if (state_q == ST_IDLE && accept && req.action == ACT_INIT)
				vld_q <= '0;
			else if (mem_we)
				vld_q[mem_wa] <= 1'b1;
		end
	end

	// Control and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kib_q <= KIB_RESET;
			bc_q <= CW'(BC_RESET);
			used_q <= CW'(BC_RESET);
			pend_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				kib_q <= cfg_wr_data;
			if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			if (state_q == ST_DONE && out_free)
				rsp_valid_q <= 1'b1;
			pend_s1 <= (state_q == ST_SCAN) && mem_re;
			if (state_q == ST_IDLE && accept && req.action == ACT_INIT) begin
				bc_q <= cfg_count;
				used_q <= cfg_count;
			end
			if (state_q == ST_MRD)
				used_q <= up_q ? cup : cdown;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				addr_q <= '0;
				ok_q <= (req.action == ACT_INIT || req.action == ACT_FREE_RUN ||
					req.action == ACT_RELEASE || req.action == ACT_RESERVE) &&
					!(req.action == ACT_FREE_RUN && req.run_length == '0);
				start_q <= st_dec;
				last_q <= last_dec;
				wcur_q <= st_dec[XW-1:BW];
				n_q <= CW'(n_clip);
				set_q <= (req.action == ACT_RESERVE);
				up_q <= (req.action == ACT_RESERVE);
				release_q <= (req.action == ACT_RELEASE);
				len_q <= len_a;
				run_q <= '0;
				rd_idx_q <= '0;
				scan_q <= scan_dec;
				ev_idx_s1 <= '0;
			end
			ST_SCAN: begin
				if (mem_re) begin
					rd_idx_q <= rd_idx_q + (AW+1)'(1);
					ev_idx_s1 <= rd_idx_q[AW-1:0];
				end
				if (pend_s1)
					run_q <= run_nx;
				if (scan_hit) begin
					ok_q <= 1'b1;
					addr_q <= ADDR_W'(hit_first) << BSH;
					start_q <= hit_first;
					last_q <= hit_last;
					wcur_q <= hit_first[XW-1:BW];
					n_q <= CW'(len_q);
					set_q <= 1'b1;
					up_q <= 1'b1;
				end
			end
			ST_MWR: begin
				if (wcur_q != we)
					wcur_q <= wcur_q + AW'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					rsp_q.ok <= ok_q;
					rsp_q.block_address <= addr_q;
					rsp_q.used_count <= CNT_W'(used_q);
					rsp_q.free_count <= CNT_W'(bc_q - used_q);
				end
			end
			default: ;
		endcase
	end

endmodule
